// File: rtl/pctd_pkg.sv
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int INODE_W  = 32;
    localparam int OFFSET_W = 32;
    localparam int DEV_W    = 8;
    localparam int PAGE_W   = 20;
    localparam int INPAGE_W = 12;
    localparam int SLOT_W   = 4;
    localparam int TAG_W    = INODE_W + PAGE_W + DEV_W;

    localparam logic ACT_READ   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_FILL     = 2'd1,
        ST_FAIL     = 2'd2,
        ST_UPD_MISS = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // request as seen by the scan controller
    typedef struct packed {
        logic             action;
        logic             fill_ok;
        logic [TAG_W-1:0] tag;
    } t_req;

    typedef struct packed {
        logic              done;
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_res;

endpackage

// File: rtl/pctd_ram.sv
`timescale 1ns / 1ps

module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pctd_ctrl.sv
`timescale 1ns / 1ps

module pctd_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  pctd_pkg::t_req         i_req,
    output logic                   o_busy,
    output logic                   o_ram_we,
    output logic [$clog2(ENTRIES)-1:0] o_ram_waddr,
    output logic [pctd_pkg::TAG_W-1:0] o_ram_wdata,
    output logic [$clog2(ENTRIES)-1:0] o_ram_raddr,
    input  logic [pctd_pkg::TAG_W-1:0] i_ram_rdata,
    output pctd_pkg::t_res         o_res
);

    import pctd_pkg::*;

    localparam int IDXW = $clog2(ENTRIES);
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRIES);
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [IDXW-1:0]     r_cmp_idx;
    logic                r_cmp_vld;
    logic [IDXW-1:0]     r_victim, n_victim;
    logic [ENTRIES-1:0]  r_valid, n_valid;

    logic w_issue;
    logic w_match;
    logic w_last;
    logic w_hit;
    logic w_miss;
    logic w_alloc;

    // compare stage sees the word read for r_cmp_idx
    assign w_issue = (r_cnt < CNT_END);
    assign w_match = (r_state == S_SCAN) && r_cmp_vld && r_valid[r_cmp_idx]
                     && (i_ram_rdata == i_req.tag);
    assign w_last  = (r_state == S_SCAN) && r_cmp_vld && (r_cmp_idx == IDX_LAST);
    assign w_hit   = w_match;
    assign w_miss  = w_last && !w_match;
    assign w_alloc = w_miss && (i_req.action == ACT_READ);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit || w_miss) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy      = 1'b0;
        o_ram_raddr = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_victim;
        o_ram_wdata = i_req.tag;
        o_res       = '0;
        n_cnt       = r_cnt;
        n_victim    = r_victim;
        n_valid     = r_valid;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
            end
            S_SCAN: begin
                o_busy = 1'b1;
                if (w_issue) begin
                    o_ram_raddr = r_cnt[IDXW-1:0];
                    n_cnt       = r_cnt + CNTW'(1);
                end
                if (w_hit) begin
                    o_res.done   = 1'b1;
                    o_res.status = ST_HIT;
                    o_res.slot   = SLOT_W'(r_cmp_idx);
                end else if (w_miss && !w_alloc) begin
                    o_res.done   = 1'b1;
                    o_res.status = ST_UPD_MISS;
                end else if (w_alloc) begin
                    o_res.done         = 1'b1;
                    o_res.status       = i_req.fill_ok ? ST_FILL : ST_FAIL;
                    o_res.slot         = SLOT_W'(r_victim);
                    o_ram_we           = i_req.fill_ok;
                    n_valid[r_victim]  = i_req.fill_ok;
                    n_victim = (r_victim == IDX_LAST) ? '0 : r_victim + IDXW'(1);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_victim  <= '0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cmp_vld <= (r_state == S_SCAN) && w_issue && !w_hit;
            r_victim  <= n_victim;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[IDXW-1:0];
    end

endmodule

// File: rtl/page_cache_tag_directory.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake        | Word
// request  | in        | i_start, o_busy  | i_action, i_inode_number, i_byte_offset,
//          |           |                  | i_device, i_fill_ok
// result   | out       | o_done strobe    | o_status, o_slot, o_page_offset, o_page_base
//
// A request is taken when i_start is high and o_busy low. The tag scan reads one
// entry per cycle from the tag RAM and compares each word in the next cycle; the scan
// ends early on a hit.
// The result strobe lasts one cycle; o_busy drops in that cycle.
// Reset clears all valid bits and the victim pointer at once; no clearing pass.
// The receiver cannot stall. PAGE_BYTES must be a power of two; nothing checks it.

module page_cache_tag_directory #(
    parameter int ENTRIES    = pctd_pkg::ENTRIES_DEF,
    parameter int PAGE_BYTES = pctd_pkg::PAGE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_action,
    input  logic [pctd_pkg::INODE_W-1:0]    i_inode_number,
    input  logic [pctd_pkg::OFFSET_W-1:0]   i_byte_offset,
    input  logic [pctd_pkg::DEV_W-1:0]      i_device,
    input  logic                            i_fill_ok,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [pctd_pkg::SLOT_W-1:0]     o_slot,
    output logic [pctd_pkg::INPAGE_W-1:0]   o_page_offset,
    output logic [pctd_pkg::PAGE_W-1:0]     o_page_base
);

    import pctd_pkg::*;

    localparam int IDXW       = $clog2(ENTRIES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'(PAGE_BYTES - 1);

    t_req                 r_req;
    logic [INPAGE_W-1:0]  r_in_page;
    t_res                 r_res;
    t_res                 w_res;
    logic                 w_accept;
    logic [OFFSET_W-1:0]  w_page_full;
    logic [OFFSET_W-1:0]  w_in_page_full;

    logic                 w_ram_we;
    logic [IDXW-1:0]      w_ram_waddr;
    logic [TAG_W-1:0]     w_ram_wdata;
    logic [IDXW-1:0]      w_ram_raddr;
    logic [TAG_W-1:0]     w_ram_rdata;

    assign w_accept       = i_start && !o_busy;
    assign w_page_full    = i_byte_offset >> PAGE_SHIFT;
    assign w_in_page_full = i_byte_offset & OFF_MASK;

    // request word held until the next accept; it also feeds the result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.action  <= i_action;
            r_req.fill_ok <= i_fill_ok;
            r_req.tag     <= {i_inode_number, w_page_full[PAGE_W-1:0], i_device};
            r_in_page     <= w_in_page_full[INPAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= w_res;
        end
    end

    pctd_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_req       (r_req),
        .o_busy      (o_busy),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_res       (w_res)
    );

    pctd_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_done        = r_res.done;
    assign o_status      = r_res.status;
    assign o_slot        = r_res.slot;
    assign o_page_offset = r_in_page;
    assign o_page_base   = r_req.tag[DEV_W +: PAGE_W];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pctd_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int PAGE_BYTES   = PAGE_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1280;
    localparam int SETTLE       = ENTRIES + 6;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [INPAGE_W-1:0]   page_offset;
        logic [PAGE_W-1:0]     page_base;
    } t_lookup_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  i_action = ACT_READ;
    logic [INODE_W-1:0]    i_inode_number = '0;
    logic [OFFSET_W-1:0]   i_byte_offset = '0;
    logic [DEV_W-1:0]      i_device = '0;
    logic                  i_fill_ok = 1'b0;
    logic                  o_busy;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [SLOT_W-1:0]     o_slot;
    logic [INPAGE_W-1:0]   o_page_offset;
    logic [PAGE_W-1:0]     o_page_base;

    // shadow copy of the tag directory
    logic [INODE_W-1:0]    shadow_inode [ENTRIES];
    logic [PAGE_W-1:0]     shadow_page [ENTRIES];
    logic [DEV_W-1:0]      shadow_dev [ENTRIES];
    logic                  shadow_valid [ENTRIES];
    int                    shadow_victim;

    t_lookup_result        pending_lookups [$];
    t_lookup_result        oldest;
    int                    errors = 0;
    int                    cycle_count = 0;
    bit                    no_idle = 1'b0;

    page_cache_tag_directory dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_inode_number (i_inode_number),
        .i_byte_offset  (i_byte_offset),
        .i_device       (i_device),
        .i_fill_ok      (i_fill_ok),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_page_offset  (o_page_offset),
        .o_page_base    (o_page_base)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // looks a request up in the shadow directory and applies its side effects
    function automatic t_lookup_result resolve_request(input logic act,
                                                       input logic [INODE_W-1:0] ino,
                                                       input logic [OFFSET_W-1:0] off,
                                                       input logic [DEV_W-1:0] dev,
                                                       input logic ok);
        t_lookup_result r;
        logic [PAGE_W-1:0] pg;
        int hit;
        pg = PAGE_W'(off / PAGE_BYTES);
        r.page_base = pg;
        r.page_offset = INPAGE_W'(off % PAGE_BYTES);
        hit = -1;
        // scan downward so the lowest matching entry wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (shadow_valid[i] && shadow_inode[i] == ino && shadow_page[i] == pg &&
                shadow_dev[i] == dev)
                hit = i;
        end
        if (hit >= 0) begin
            r.status = ST_HIT;
            r.slot = SLOT_W'(hit);
        end else if (act == ACT_UPDATE) begin
            r.status = ST_UPD_MISS;
            r.slot = '0;
        end else begin
            r.slot = SLOT_W'(shadow_victim);
            if (ok) begin
                shadow_inode[shadow_victim] = ino;
                shadow_page[shadow_victim] = pg;
                shadow_dev[shadow_victim] = dev;
                shadow_valid[shadow_victim] = 1'b1;
                r.status = ST_FILL;
            end else begin
                // failed fill wipes the page, slot is still consumed
                shadow_valid[shadow_victim] = 1'b0;
                r.status = ST_FAIL;
            end
            shadow_victim = (shadow_victim + 1) % ENTRIES;
        end
        return r;
    endfunction

    task automatic send_request(input logic act, input logic [INODE_W-1:0] ino,
                                input logic [OFFSET_W-1:0] off, input logic [DEV_W-1:0] dev,
                                input logic ok);
        if (!no_idle && $urandom_range(99) < 22) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_action <= act;
        i_inode_number <= ino;
        i_byte_offset <= off;
        i_device <= dev;
        i_fill_ok <= ok;
        do @(posedge i_clk); while (o_busy);
        pending_lookups.push_back(resolve_request(act, ino, off, dev, ok));
    endtask

    task automatic wait_for_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0);
    endtask

    task automatic test_empty_directory();
        // cleared valid bits must keep the all-zero tag from matching
        send_request(ACT_UPDATE, '0, '0, '0, 1'b1);
        send_request(ACT_READ, '0, '0, '0, 1'b0);
        send_request(ACT_UPDATE, '0, '0, '0, 1'b0);
    endtask

    task automatic test_fill_and_hit();
        send_request(ACT_READ, '0, '0, '0, 1'b1);
        send_request(ACT_READ, '0, 32'h0000_0fff, '0, 1'b0);
        send_request(ACT_UPDATE, '0, 32'h0000_1000, '0, 1'b1);
        send_request(ACT_READ, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 1'b1);
        send_request(ACT_UPDATE, 32'hffff_ffff, 32'hffff_f000, 8'hff, 1'b0);
        send_request(ACT_READ, 32'hffff_ffff, 32'hffff_ffff, 8'hfe, 1'b1);
        send_request(ACT_READ, 32'hffff_fffe, 32'hffff_ffff, 8'hff, 1'b1);
    endtask

    task automatic test_replacement_wrap();
        // run the victim pointer past the last entry, then fail a fill on a live slot
        for (int k = 0; k < 12; k++)
            send_request(ACT_READ, 32'h100 + k, k * PAGE_BYTES, 8'(k), 1'b1);
        send_request(ACT_READ, 32'h5a5a_a5a5, 32'h8000_0123, 8'h80, 1'b0);
        send_request(ACT_UPDATE, '0, '0, '0, 1'b1);
        send_request(ACT_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [INODE_W-1:0] ino_set [6];
        logic [DEV_W-1:0] dev_set [2];
        logic [PAGE_W-1:0] page_set [4];
        logic act;
        logic [INODE_W-1:0] ino;
        logic [OFFSET_W-1:0] off;
        logic [DEV_W-1:0] dev;
        foreach (ino_set[i]) ino_set[i] = $urandom();
        foreach (dev_set[i]) dev_set[i] = DEV_W'($urandom());
        foreach (page_set[i]) page_set[i] = PAGE_W'($urandom());
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 400 && n < 650);
            if (n == 800)
                wait_for_results();
            // mostly a small working set so hits, evictions and near misses occur
            if ($urandom_range(99) < 75) begin
                ino = ino_set[$urandom_range(5)];
                dev = dev_set[$urandom_range(1)];
                off = {page_set[$urandom_range(3)], INPAGE_W'($urandom())};
            end else begin
                ino = $urandom();
                dev = DEV_W'($urandom());
                off = $urandom();
            end
            act = ($urandom_range(99) < 30) ? ACT_UPDATE : ACT_READ;
            send_request(act, ino, off, dev, $urandom_range(99) < 85);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with nothing pending: status %0d slot %0d", $time,
                         o_status, o_slot);
                errors++;
            end else begin
                oldest = pending_lookups.pop_front();
                if (oldest.status != t_status'(o_status)) begin
                    $display("%0t: status expected %0d actual %0d", $time, oldest.status,
                             o_status);
                    errors++;
                end
                if (oldest.slot != o_slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, oldest.slot, o_slot);
                    errors++;
                end
                if (oldest.page_offset != o_page_offset) begin
                    $display("%0t: page_offset expected %h actual %h", $time,
                             oldest.page_offset, o_page_offset);
                    errors++;
                end
                if (oldest.page_base != o_page_base) begin
                    $display("%0t: page_base expected %h actual %h", $time,
                             oldest.page_base, o_page_base);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_inode[i] = '0;
            shadow_page[i] = '0;
            shadow_dev[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        shadow_victim = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_directory();
        test_fill_and_hit();
        test_replacement_wrap();
        test_random_traffic();
        wait_for_results();
        // catch any stray strobe after the last word
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/pctd_pkg.sv
rtl/pctd_ram.sv
rtl/pctd_ctrl.sv
rtl/page_cache_tag_directory.sv
tb/tb_top.sv
